// File: hw/rtl/resp_stream_deframer_assert.svh
// ---------------------------------------------------------------------------
// resp_stream_deframer_assert.svh
// Assertion macros used by the deframer parser (rsd_parser).
// ---------------------------------------------------------------------------
`ifndef RESP_STREAM_DEFRAMER_ASSERT_SVH
`define RESP_STREAM_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define RSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rsd_pkg.sv
// ---------------------------------------------------------------------------
// rsd_pkg
// Types, codes and byte constants of the RESP stream deframer.
// ---------------------------------------------------------------------------
package rsd_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_LINE    = 4'd1,
    PH_LINE_LF = 4'd2,
    PH_BLEN    = 4'd3,
    PH_BLEN_LF = 4'd4,
    PH_BODY    = 4'd5,
    PH_BODY_CR = 4'd6,
    PH_BODY_LF = 4'd7,
    PH_ALEN    = 4'd8,
    PH_ALEN_LF = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ET_SIMPLE  = 3'd0,
    ET_ERROR   = 3'd1,
    ET_INTEGER = 3'd2,
    ET_BULK    = 3'd3,
    ET_NIL     = 3'd4,
    ET_ARRAY   = 3'd5
  } elem_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_DIGIT = 3'd1,
    ERR_NESTED    = 3'd2,
    ERR_UNKNOWN   = 3'd3,
    ERR_NO_CRLF   = 3'd4,
    ERR_TRUNC     = 3'd5,
    ERR_OVERFLOW  = 3'd6,
    ERR_STRAY_CR  = 3'd7
  } err_t;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int TDATA_W = 32;
  localparam int TUSER_W = 3;

  typedef struct packed {
    elem_t       elem_type;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        elem_end;
    logic [15:0] header_count;
    logic        in_array;
    logic        array_done;
    err_t        err_code;
  } res_t;

  function automatic res_t mk_res(elem_t t, logic [7:0] b, logic dv, logic e,
                                  logic [15:0] cnt, logic ia, logic dn, err_t ec);
    res_t r;
    r.elem_type    = t;
    r.data_byte    = b;
    r.data_valid   = dv;
    r.elem_end     = e;
    r.header_count = cnt;
    r.in_array     = ia;
    r.array_done   = dn;
    r.err_code     = ec;
    return r;
  endfunction

endpackage

// File: hw/rtl/rsd_in_reg.sv
// ---------------------------------------------------------------------------
// rsd_in_reg
// Input register: captures one byte word and its end-of-buffer mark.
// ---------------------------------------------------------------------------
module rsd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       advance,
  output logic       hold_valid,
  output logic [7:0] hold_byte,
  output logic       hold_last
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;
  assign hold_last  = last_r;

endmodule

// File: hw/rtl/rsd_parser.sv
// ---------------------------------------------------------------------------
// rsd_parser
// Protocol state and per-byte decision logic; at most one result per byte.
// ---------------------------------------------------------------------------
`include "resp_stream_deframer_assert.svh"

module rsd_parser #(
  parameter int LEN_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    c,
  input  logic          last,
  output logic          res_valid,
  output rsd_pkg::res_t res
);

  localparam int ACC_W = (LEN_BITS > COUNT_BITS) ? LEN_BITS : COUNT_BITS;
  localparam int NXT_W = ACC_W + 4;

  rsd_pkg::phase_t       phase_r, phase_nxt;
  rsd_pkg::elem_t        kind_r, kind_nxt;
  logic [ACC_W-1:0]      accum_r, accum_nxt;
  logic [LEN_BITS-1:0]   payload_r, payload_nxt;
  logic [COUNT_BITS-1:0] arr_left_r, arr_left_nxt;
  logic                  inside_r, inside_nxt;
  logic                  discard_r, discard_nxt;
  logic                  digit_r, digit_nxt;
  logic                  minus_r, minus_nxt;

  logic                  is_digit;
  logic [NXT_W-1:0]      acc_ext;
  logic [NXT_W-1:0]      acc10;
  logic                  ovf_len;
  logic                  ovf_cnt;
  logic [ACC_W+15:0]     cnt_ext;
  logic [LEN_BITS-1:0]   payload_dec;
  logic [COUNT_BITS-1:0] arr_dec;

  assign is_digit    = (c >= rsd_pkg::CH_ZERO) && (c <= rsd_pkg::CH_NINE);
  assign acc_ext     = {4'b0, accum_r};
  assign acc10       = (acc_ext << 3) + (acc_ext << 1) + NXT_W'(c[3:0]);
  assign ovf_len     = |acc10[NXT_W-1:LEN_BITS];
  assign ovf_cnt     = |acc10[NXT_W-1:COUNT_BITS];
  assign cnt_ext     = {16'b0, accum_r};
  assign payload_dec = payload_r - LEN_BITS'(1);
  assign arr_dec     = arr_left_r - COUNT_BITS'(1);

  always_comb begin
    rsd_pkg::res_t r;
    logic          rv;
    logic          fail;
    rsd_pkg::elem_t ftype;
    rsd_pkg::err_t  fcode;
    logic          fin;
    rsd_pkg::elem_t fin_type;
    logic          done;

    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    accum_nxt    = accum_r;
    payload_nxt  = payload_r;
    arr_left_nxt = arr_left_r;
    inside_nxt   = inside_r;
    discard_nxt  = discard_r;
    digit_nxt    = digit_r;
    minus_nxt    = minus_r;
    r            = '0;
    rv           = 1'b0;
    fail         = 1'b0;
    ftype        = rsd_pkg::ET_SIMPLE;
    fcode        = rsd_pkg::ERR_NONE;
    fin          = 1'b0;
    fin_type     = rsd_pkg::ET_SIMPLE;
    done         = 1'b0;

    if (!discard_r) begin
      unique case (phase_r)
        rsd_pkg::PH_IDLE: begin
          case (c)
            rsd_pkg::CH_PLUS: begin
              phase_nxt = rsd_pkg::PH_LINE;
              kind_nxt  = rsd_pkg::ET_SIMPLE;
            end
            rsd_pkg::CH_MINUS: begin
              phase_nxt = rsd_pkg::PH_LINE;
              kind_nxt  = rsd_pkg::ET_ERROR;
            end
            rsd_pkg::CH_COLON: begin
              phase_nxt = rsd_pkg::PH_LINE;
              kind_nxt  = rsd_pkg::ET_INTEGER;
            end
            rsd_pkg::CH_DOLLAR: begin
              phase_nxt = rsd_pkg::PH_BLEN;
              kind_nxt  = rsd_pkg::ET_BULK;
              accum_nxt = '0;
              digit_nxt = 1'b0;
              minus_nxt = 1'b0;
            end
            rsd_pkg::CH_STAR: begin
              kind_nxt = rsd_pkg::ET_ARRAY;
              if (inside_r) begin
                fail  = 1'b1;
                ftype = rsd_pkg::ET_ARRAY;
                fcode = rsd_pkg::ERR_NESTED;
              end else begin
                phase_nxt = rsd_pkg::PH_ALEN;
                accum_nxt = '0;
                digit_nxt = 1'b0;
                minus_nxt = 1'b0;
              end
            end
            rsd_pkg::CH_CR: begin
              kind_nxt = rsd_pkg::ET_SIMPLE;
              fail     = 1'b1;
              fcode    = rsd_pkg::ERR_STRAY_CR;
            end
            default: begin
              kind_nxt = rsd_pkg::ET_SIMPLE;
              fail     = 1'b1;
              fcode    = rsd_pkg::ERR_UNKNOWN;
            end
          endcase
        end
        rsd_pkg::PH_LINE: begin
          if (c == rsd_pkg::CH_CR) begin
            phase_nxt = rsd_pkg::PH_LINE_LF;
          end else begin
            rv = 1'b1;
            r  = rsd_pkg::mk_res(kind_r, c, 1'b1, 1'b0, 16'd0, inside_r, 1'b0,
                                 rsd_pkg::ERR_NONE);
          end
        end
        rsd_pkg::PH_LINE_LF: begin
          if (c == rsd_pkg::CH_LF) begin
            fin      = 1'b1;
            fin_type = kind_r;
          end else begin
            fail  = 1'b1;
            ftype = kind_r;
            fcode = rsd_pkg::ERR_STRAY_CR;
          end
        end
        rsd_pkg::PH_BLEN: begin
          ftype = kind_r;
          if (c == rsd_pkg::CH_CR) begin
            if (digit_r) begin
              phase_nxt = rsd_pkg::PH_BLEN_LF;
            end else begin
              fail  = 1'b1;
              fcode = rsd_pkg::ERR_BAD_DIGIT;
            end
          end else if (c == rsd_pkg::CH_MINUS) begin
            if (digit_r || minus_r) begin
              fail  = 1'b1;
              fcode = rsd_pkg::ERR_BAD_DIGIT;
            end else begin
              minus_nxt = 1'b1;
            end
          end else if (is_digit) begin
            if (minus_r) begin
              if (digit_r || (c != rsd_pkg::CH_ONE)) begin
                fail  = 1'b1;
                fcode = rsd_pkg::ERR_BAD_DIGIT;
              end else begin
                digit_nxt = 1'b1;
              end
            end else if (ovf_len) begin
              fail  = 1'b1;
              fcode = rsd_pkg::ERR_OVERFLOW;
            end else begin
              accum_nxt = acc10[ACC_W-1:0];
              digit_nxt = 1'b1;
            end
          end else begin
            fail  = 1'b1;
            fcode = rsd_pkg::ERR_BAD_DIGIT;
          end
        end
        rsd_pkg::PH_BLEN_LF: begin
          if (c != rsd_pkg::CH_LF) begin
            fail  = 1'b1;
            ftype = kind_r;
            fcode = rsd_pkg::ERR_STRAY_CR;
          end else if (minus_r) begin
            kind_nxt = rsd_pkg::ET_NIL;
            fin      = 1'b1;
            fin_type = rsd_pkg::ET_NIL;
          end else if (accum_r == '0) begin
            phase_nxt = rsd_pkg::PH_BODY_CR;
          end else begin
            payload_nxt = accum_r[LEN_BITS-1:0];
            phase_nxt   = rsd_pkg::PH_BODY;
          end
        end
        rsd_pkg::PH_BODY: begin
          rv          = 1'b1;
          r           = rsd_pkg::mk_res(rsd_pkg::ET_BULK, c, 1'b1, 1'b0, 16'd0, inside_r,
                                        1'b0, rsd_pkg::ERR_NONE);
          payload_nxt = payload_dec;
          if (payload_dec == '0) begin
            phase_nxt = rsd_pkg::PH_BODY_CR;
          end
        end
        rsd_pkg::PH_BODY_CR: begin
          if (c == rsd_pkg::CH_CR) begin
            phase_nxt = rsd_pkg::PH_BODY_LF;
          end else begin
            fail  = 1'b1;
            ftype = rsd_pkg::ET_BULK;
            fcode = rsd_pkg::ERR_NO_CRLF;
          end
        end
        rsd_pkg::PH_BODY_LF: begin
          if (c == rsd_pkg::CH_LF) begin
            fin      = 1'b1;
            fin_type = rsd_pkg::ET_BULK;
          end else begin
            fail  = 1'b1;
            ftype = rsd_pkg::ET_BULK;
            fcode = rsd_pkg::ERR_NO_CRLF;
          end
        end
        rsd_pkg::PH_ALEN: begin
          ftype = rsd_pkg::ET_ARRAY;
          if (c == rsd_pkg::CH_CR) begin
            if (digit_r) begin
              phase_nxt = rsd_pkg::PH_ALEN_LF;
            end else begin
              fail  = 1'b1;
              fcode = rsd_pkg::ERR_BAD_DIGIT;
            end
          end else if (is_digit) begin
            if (ovf_cnt) begin
              fail  = 1'b1;
              fcode = rsd_pkg::ERR_OVERFLOW;
            end else begin
              accum_nxt = acc10[ACC_W-1:0];
              digit_nxt = 1'b1;
            end
          end else begin
            fail  = 1'b1;
            fcode = rsd_pkg::ERR_BAD_DIGIT;
          end
        end
        rsd_pkg::PH_ALEN_LF: begin
          if (c != rsd_pkg::CH_LF) begin
            fail  = 1'b1;
            ftype = rsd_pkg::ET_ARRAY;
            fcode = rsd_pkg::ERR_STRAY_CR;
          end else begin
            phase_nxt = rsd_pkg::PH_IDLE;
            rv        = 1'b1;
            if (accum_r == '0) begin
              r = rsd_pkg::mk_res(rsd_pkg::ET_ARRAY, 8'd0, 1'b0, 1'b1, 16'd0, 1'b0,
                                  1'b1, rsd_pkg::ERR_NONE);
            end else begin
              inside_nxt   = 1'b1;
              arr_left_nxt = accum_r[COUNT_BITS-1:0];
              r = rsd_pkg::mk_res(rsd_pkg::ET_ARRAY, 8'd0, 1'b0, 1'b1, cnt_ext[15:0],
                                  1'b0, 1'b0, rsd_pkg::ERR_NONE);
            end
          end
        end
        default: begin
          phase_nxt = rsd_pkg::PH_IDLE;
        end
      endcase

      if (fail) begin
        discard_nxt = 1'b1;
        rv          = 1'b1;
        r = rsd_pkg::mk_res(ftype, 8'd0, 1'b0, 1'b0, 16'd0, inside_r, 1'b0, fcode);
      end

      if (fin) begin
        if (inside_r) begin
          arr_left_nxt = arr_dec;
          if (arr_dec == '0) begin
            done       = 1'b1;
            inside_nxt = 1'b0;
          end
        end
        phase_nxt = rsd_pkg::PH_IDLE;
        rv        = 1'b1;
        r = rsd_pkg::mk_res(fin_type, 8'd0, 1'b0, 1'b1, 16'd0, inside_r, done,
                            rsd_pkg::ERR_NONE);
      end

      // end of buffer with an element or array still open
      if (last && !discard_nxt && ((phase_nxt != rsd_pkg::PH_IDLE) || inside_nxt)) begin
        rv = 1'b1;
        r  = rsd_pkg::mk_res((phase_nxt != rsd_pkg::PH_IDLE) ? kind_nxt : rsd_pkg::ET_ARRAY,
                             8'd0, 1'b0, 1'b0, 16'd0, inside_nxt, 1'b0,
                             rsd_pkg::ERR_TRUNC);
        discard_nxt = 1'b1;
      end
    end

    if (last && discard_nxt) begin
      phase_nxt    = rsd_pkg::PH_IDLE;
      kind_nxt     = rsd_pkg::ET_SIMPLE;
      accum_nxt    = '0;
      payload_nxt  = '0;
      arr_left_nxt = '0;
      inside_nxt   = 1'b0;
      discard_nxt  = 1'b0;
      digit_nxt    = 1'b0;
      minus_nxt    = 1'b0;
    end

    res_valid = rv;
    res       = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rsd_pkg::PH_IDLE;
      kind_r     <= rsd_pkg::ET_SIMPLE;
      accum_r    <= '0;
      payload_r  <= '0;
      arr_left_r <= '0;
      inside_r   <= 1'b0;
      discard_r  <= 1'b0;
      digit_r    <= 1'b0;
      minus_r    <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
      accum_r    <= accum_nxt;
      payload_r  <= payload_nxt;
      arr_left_r <= arr_left_nxt;
      inside_r   <= inside_nxt;
      discard_r  <= discard_nxt;
      digit_r    <= digit_nxt;
      minus_r    <= minus_nxt;
    end
  end

  `RSD_ASSERT_NOW(a_err_no_payload, clk, rst_n,
    res_valid && (res.err_code != rsd_pkg::ERR_NONE),
    !res.data_valid && !res.elem_end && !res.array_done, "error result carries payload")
  `RSD_ASSERT_NOW(a_discard_silent, clk, rst_n, discard_r, !res_valid,
    "result produced while discarding")
  `RSD_ASSERT_NOW(a_array_count_live, clk, rst_n, inside_r, arr_left_r != '0,
    "inside array with zero elements left")
  `RSD_ASSERT_NEXT(a_last_resets, clk, rst_n, step && last,
    (phase_r == rsd_pkg::PH_IDLE) && !inside_r && !discard_r,
    "state not cleared after buffer end")

endmodule

// File: hw/rtl/rsd_out_reg.sv
// ---------------------------------------------------------------------------
// rsd_out_reg
// Result register: holds one result word until the sink takes it.
// ---------------------------------------------------------------------------
module rsd_out_reg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  rsd_pkg::res_t                res,
  output logic                         can_load,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rsd_pkg::TDATA_W-1:0]  out_tdata,
  output logic [rsd_pkg::TUSER_W-1:0]  out_tuser,
  output logic                         out_tlast
);

  logic          valid_r;
  logic          valid_nxt;
  rsd_pkg::res_t res_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.elem_type;
  assign out_tlast  = res_r.elem_end;
  assign out_tdata  = {2'b00, res_r.err_code, res_r.array_done, res_r.in_array,
                       res_r.header_count, res_r.data_valid, res_r.data_byte};

endmodule

// File: hw/rtl/resp_stream_deframer.sv
// ---------------------------------------------------------------------------
// resp_stream_deframer
// Byte-serial RESP2 deframer: typed payload words, element ends, array headers.
//
//   channel  dir  word                  tdata / tuser / tlast
//   in_      in   one buffer byte       tdata[7:0] byte, tlast end of buffer
//   out_     out  one decoded result    tdata fields below, tuser type, tlast elem end
//
// One byte per cycle sustained while the sink does not stall; an accepted byte
// waits in the input register, then its result word goes to the result register.
// Per-byte cost is set by the length accumulator (multiply by ten and add).
// Synchronous active-low reset clears all parser state and both stage valids.
// A stalled result holds in the output register; one more byte may wait in
// the input register before in_tready drops.
// ---------------------------------------------------------------------------
module resp_stream_deframer #(
  parameter int LEN_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] data_byte, [8] data_valid, [24:9] header_count,
                                   // [25] in_array, [26] array_done, [29:27] err_code
  output logic [2:0]  out_tuser,   // [2:0] elem_type
  output logic        out_tlast    // elem_end
);

  logic          hold_valid;
  logic [7:0]    hold_byte;
  logic          hold_last;
  logic          can_load;
  logic          step;
  logic          res_valid;
  rsd_pkg::res_t res;

  assign step = hold_valid && can_load;

  rsd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .advance    (can_load),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .hold_last  (hold_last)
  );

  rsd_parser #(
    .LEN_BITS   (LEN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .c         (hold_byte),
    .last      (hold_last),
    .res_valid (res_valid),
    .res       (res)
  );

  rsd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && res_valid),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
